/* design/arot_pkg.sv */
// shared types, constants and the cordic arctangent table for the axis rotation block
`timescale 1ns / 1ps

package arot_pkg;

  // default sizes, handed down from the top level parameters
  localparam int COORD_WIDTH_DEF = 32;
  localparam int TRIG_STAGES_DEF = 16;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int ANGLE_W   = 16;
  localparam int ANG_EXT_W = ANGLE_W + 1;
  localparam int TRIG_W    = 32;

  // number of arctangent entries available to the stages
  localparam int ATAN_ENTRIES = 24;

  // start vector length, 0.60725293500888 in q2.30
  localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // angle limits in 1/128 degree
  localparam logic signed [ANG_EXT_W-1:0] HALF_TURN    = 17'sd23040;
  localparam logic signed [ANG_EXT_W-1:0] QUARTER_TURN = 17'sd11520;
  localparam logic signed [ANG_EXT_W-1:0] FULL_TURN    = 17'sd46080;

  // rotation axis selector
  typedef enum logic [CMD_W-1:0] {
    CMD_ROT_X = 2'd0,
    CMD_ROT_Y = 2'd1,
    CMD_ROT_Z = 2'd2,
    CMD_PASS  = 2'd3
  } cmd_t;

  // cordic vector and residual angle (degrees * 2^23)
  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } cordic_t;

  // atan(2^-i) in degrees * 2^23, rounded
  function automatic logic signed [TRIG_W-1:0] atan_deg23(input int idx);
    logic signed [TRIG_W-1:0] v;
    case (idx)
      0:       v = 32'sd377487360;
      1:       v = 32'sd222843801;
      2:       v = 32'sd117744544;
      3:       v = 32'sd59768969;
      4:       v = 32'sd30000467;
      5:       v = 32'sd15014858;
      6:       v = 32'sd7509261;
      7:       v = 32'sd3754860;
      8:       v = 32'sd1877459;
      9:       v = 32'sd938733;
      10:      v = 32'sd469367;
      11:      v = 32'sd234683;
      12:      v = 32'sd117342;
      13:      v = 32'sd58671;
      14:      v = 32'sd29335;
      15:      v = 32'sd14668;
      16:      v = 32'sd7334;
      17:      v = 32'sd3667;
      18:      v = 32'sd1833;
      19:      v = 32'sd917;
      20:      v = 32'sd458;
      21:      v = 32'sd229;
      22:      v = 32'sd115;
      23:      v = 32'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/axis_rotation_of_3d_point.sv */
// top: principal axis rotation of one 3d point, one item per cycle unless stalled
//
//  channel  dir  handshake            payload
//  in_      in   in_tvalid/in_tready  tdata: in_x, in_y, in_z, angle; tuser: command
//  out_     out  out_tvalid/out_tready tdata: out_x, out_y, out_z
//
// one item enters per cycle unless the output stalls; it passes one fold stage,
// one register per cordic cell, then select, multiply, partial sum and round/saturate.
// reset clears only the valid bits of the stages; payload registers are not reset.
// a stalled output holds the last stage; stages behind it keep filling until the
// pipeline is full, so in_tready stays high while any stage is empty.
`timescale 1ns / 1ps

module axis_rotation_of_3d_point #(
  parameter int COORD_WIDTH = arot_pkg::COORD_WIDTH_DEF,
  parameter int TRIG_STAGES = arot_pkg::TRIG_STAGES_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // in_x, in_y, in_z, angle, zero fill
  input  logic [((3*COORD_WIDTH+arot_pkg::ANGLE_W+7)/8)*8-1:0] in_tdata,
  // command
  input  logic [arot_pkg::CMD_W-1:0]                        in_tuser,
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // out_x, out_y, out_z, zero fill
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]                out_tdata
);
  import arot_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int OUT_W  = ((3*CW+7)/8)*8;
  localparam int PAY_W  = 3*CW + CMD_W;
  localparam int SIDE_W = PAY_W + 1;

  logic signed [ANGLE_W-1:0] angle_in;
  logic [PAY_W-1:0]          pay_in;

  logic [TRIG_STAGES:0]      cell_vld;
  logic [TRIG_STAGES:0]      cell_rdy;
  cordic_t                   cell_trig [TRIG_STAGES+1];
  logic [SIDE_W-1:0]         cell_side [TRIG_STAGES+1];

  logic signed [CW-1:0]      res_x, res_y, res_z;

  // unpack the input item
  assign angle_in = in_tdata[3*CW+ANGLE_W-1:3*CW];
  assign pay_in   = {in_tuser, in_tdata[3*CW-1:0]};

  // angle fold and cordic start
  arot_angle_fold #(
    .PAY_W(PAY_W)
  ) u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_angle  (angle_in),
    .in_pay    (pay_in),
    .out_valid (cell_vld[0]),
    .out_ready (cell_rdy[0]),
    .out_trig  (cell_trig[0]),
    .out_side  (cell_side[0])
  );

  // row of cordic cells
  for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
    arot_cordic_cell #(
      .STAGE  (g),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cell_vld[g]),
      .in_ready  (cell_rdy[g]),
      .in_trig   (cell_trig[g]),
      .in_side   (cell_side[g]),
      .out_valid (cell_vld[g+1]),
      .out_ready (cell_rdy[g+1]),
      .out_trig  (cell_trig[g+1]),
      .out_side  (cell_side[g+1])
    );
  end

  // products, rounding and saturation
  arot_rot_mac #(
    .CW(CW)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cell_vld[TRIG_STAGES]),
    .in_ready  (cell_rdy[TRIG_STAGES]),
    .in_trig   (cell_trig[TRIG_STAGES]),
    .in_side   (cell_side[TRIG_STAGES]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_z     (res_z)
  );

  // pack the result item
  assign out_tdata = OUT_W'({res_z, res_y, res_x});

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with an empty output register");

  a_ready_on_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while the output drains");

endmodule

/* design/arot_angle_fold.sv */
// angle wrap and fold to +-90 degrees, loads the cordic start vector
`timescale 1ns / 1ps

module arot_angle_fold #(
  parameter int PAY_W = 98
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic signed [arot_pkg::ANGLE_W-1:0]       in_angle,
  input  logic [PAY_W-1:0]                          in_pay,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output arot_pkg::cordic_t                         out_trig,
  output logic [PAY_W:0]                            out_side
);
  import arot_pkg::*;

  // largest residual angle after the fold, degrees * 2^23
  localparam logic signed [TRIG_W-1:0] Z_LIMIT = 32'sd754974720;

  logic signed [ANG_EXT_W-1:0] ext_a;
  logic signed [ANG_EXT_W-1:0] wrap_a;
  logic signed [ANG_EXT_W-1:0] fold_a;
  logic                        flip_nxt;
  cordic_t                     trig_nxt;

  logic                        valid_r;
  cordic_t                     trig_r;
  logic [PAY_W:0]              side_r;

  // wrap modulo a full turn, then fold into the right half plane
  always_comb begin
    ext_a  = {in_angle[ANGLE_W-1], in_angle};
    wrap_a = ext_a;
    if (ext_a >= HALF_TURN) begin
      wrap_a = ext_a - FULL_TURN;
    end else if (ext_a < -HALF_TURN) begin
      wrap_a = ext_a + FULL_TURN;
    end
    fold_a   = wrap_a;
    flip_nxt = 1'b0;
    if (wrap_a > QUARTER_TURN) begin
      fold_a   = wrap_a - HALF_TURN;
      flip_nxt = 1'b1;
    end else if (wrap_a < -QUARTER_TURN) begin
      fold_a   = wrap_a + HALF_TURN;
      flip_nxt = 1'b1;
    end
    trig_nxt.x = CORDIC_GAIN;
    trig_nxt.y = '0;
    trig_nxt.z = TRIG_W'(fold_a) <<< 16;
  end

  assign in_ready = !valid_r || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      trig_r <= trig_nxt;
      side_r <= {flip_nxt, in_pay};
    end
  end

  assign out_valid = valid_r;
  assign out_trig  = trig_r;
  assign out_side  = side_r;

  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (signed'(trig_r.z) <= Z_LIMIT && signed'(trig_r.z) >= -Z_LIMIT))
    else $error("folded angle outside +-90 degrees");

  a_start_vector: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (trig_r.x == CORDIC_GAIN && trig_r.y == '0))
    else $error("cordic start vector corrupted");

endmodule

/* design/arot_cordic_cell.sv */
// one cordic rotation cell with its own stage register
`timescale 1ns / 1ps

module arot_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = 99
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  arot_pkg::cordic_t in_trig,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  input  logic              out_ready,
  output arot_pkg::cordic_t out_trig,
  output logic [SIDE_W-1:0] out_side
);
  import arot_pkg::*;

  localparam logic signed [TRIG_W-1:0] ATAN_STEP = atan_deg23(STAGE);

  logic signed [TRIG_W-1:0] dx;
  logic signed [TRIG_W-1:0] dy;
  cordic_t                  trig_nxt;

  logic                     valid_r;
  cordic_t                  trig_r;
  logic [SIDE_W-1:0]        side_r;

  // micro-rotation toward zero residual angle
  always_comb begin
    dx = signed'(in_trig.y) >>> STAGE;
    dy = signed'(in_trig.x) >>> STAGE;
    if (!in_trig.z[TRIG_W-1]) begin
      trig_nxt.x = signed'(in_trig.x) - dx;
      trig_nxt.y = signed'(in_trig.y) + dy;
      trig_nxt.z = signed'(in_trig.z) - ATAN_STEP;
    end else begin
      trig_nxt.x = signed'(in_trig.x) + dx;
      trig_nxt.y = signed'(in_trig.y) - dy;
      trig_nxt.z = signed'(in_trig.z) + ATAN_STEP;
    end
  end

  assign in_ready = !valid_r || out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      trig_r <= trig_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_trig  = trig_r;
  assign out_side  = side_r;

endmodule

/* design/arot_rot_mac.sv */
// sign selection, split products, rounding and saturation of the rotated pair
`timescale 1ns / 1ps

module arot_rot_mac #(
  parameter int CW = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  arot_pkg::cordic_t      in_trig,
  input  logic [3*CW+2:0]        in_side,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [CW-1:0]   out_x,
  output logic signed [CW-1:0]   out_y,
  output logic signed [CW-1:0]   out_z
);
  import arot_pkg::*;

  localparam int PH_W  = CW + 17;
  localparam int PL_W  = CW + 16;
  localparam int HS_W  = CW + 18;
  localparam int LS_W  = CW + 17;
  localparam int TOT_W = CW + 34;
  localparam int R_W   = CW + 4;
  localparam logic signed [LS_W-1:0] ROUND_HALF = LS_W'(1) << 29;
  localparam logic signed [TRIG_W-1:0] TRIG_BOUND = 32'sd1073807360;

  // select stage
  logic                     flip_in;
  cmd_t                     cmd_in;
  logic signed [CW-1:0]     x_in, y_in, z_in;
  logic                     neg_s;
  logic signed [CW-1:0]     p_nxt, q_nxt;
  logic signed [TRIG_W-1:0] c_nxt, sp_nxt, sn_nxt;

  logic                     v0_r;
  cmd_t                     cmd0_r;
  logic signed [CW-1:0]     x0_r, y0_r, z0_r, p0_r, q0_r;
  logic signed [TRIG_W-1:0] c0_r, sp0_r, sn0_r;

  // product stage
  logic signed [16:0]       ch, sph, snh;
  logic signed [15:0]       cl, spl, snl;
  logic                     v1_r;
  cmd_t                     cmd1_r;
  logic signed [CW-1:0]     x1_r, y1_r, z1_r;
  logic signed [PH_W-1:0]   pch1_r, qnh1_r, qch1_r, psh1_r;
  logic signed [PL_W-1:0]   pcl1_r, qnl1_r, qcl1_r, psl1_r;

  // partial sum stage
  logic                     v2_r;
  cmd_t                     cmd2_r;
  logic signed [CW-1:0]     x2_r, y2_r, z2_r;
  logic signed [HS_W-1:0]   uh2_r, vh2_r;
  logic signed [LS_W-1:0]   ul2_r, vl2_r;

  // result stage
  logic signed [CW-1:0]     u_res, v_res;
  logic signed [CW-1:0]     ox_nxt, oy_nxt, oz_nxt;
  logic                     v3_r;
  logic signed [CW-1:0]     ox_r, oy_r, oz_r;

  logic rdy0, rdy1, rdy2, rdy3;

  // floor((h * 2^15 + l) / 2^30), clamped to the coordinate range
  function automatic logic signed [CW-1:0] round_sat(input logic signed [HS_W-1:0] h,
                                                     input logic signed [LS_W-1:0] l);
    logic signed [TOT_W-1:0] tot;
    logic signed [R_W-1:0]   r;
    logic signed [CW-1:0]    res;
    tot = (TOT_W'(h) <<< 15) + TOT_W'(l);
    r   = R_W'(tot >>> 30);
    if ((&r[R_W-1:CW-1]) || !(|r[R_W-1:CW-1])) begin
      res = r[CW-1:0];
    end else if (r[R_W-1]) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = {1'b0, {(CW-1){1'b1}}};
    end
    return res;
  endfunction

  // bubble-collapsing ready chain
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign rdy0     = !v0_r || rdy1;
  assign in_ready = rdy0;

  // pick the rotating pair and the sign of the sine term
  always_comb begin
    flip_in = in_side[3*CW+2];
    cmd_in  = cmd_t'(in_side[3*CW+1:3*CW]);
    x_in    = in_side[CW-1:0];
    y_in    = in_side[2*CW-1:CW];
    z_in    = in_side[3*CW-1:2*CW];
    neg_s   = flip_in ^ (cmd_in == CMD_ROT_Y);
    c_nxt   = flip_in ? -signed'(in_trig.x) : signed'(in_trig.x);
    sp_nxt  = neg_s ? -signed'(in_trig.y) : signed'(in_trig.y);
    sn_nxt  = neg_s ? signed'(in_trig.y) : -signed'(in_trig.y);
    case (cmd_in)
      CMD_ROT_X: begin
        p_nxt = y_in;
        q_nxt = z_in;
      end
      CMD_ROT_Y: begin
        p_nxt = x_in;
        q_nxt = z_in;
      end
      default: begin
        p_nxt = x_in;
        q_nxt = y_in;
      end
    endcase
  end

  // split trig words into a signed high part and an unsigned 15-bit low part
  always_comb begin
    ch  = signed'(c0_r[TRIG_W-1:15]);
    sph = signed'(sp0_r[TRIG_W-1:15]);
    snh = signed'(sn0_r[TRIG_W-1:15]);
    cl  = signed'({1'b0, c0_r[14:0]});
    spl = signed'({1'b0, sp0_r[14:0]});
    snl = signed'({1'b0, sn0_r[14:0]});
  end

  // round, saturate and put the pair back on its axes
  always_comb begin
    u_res = round_sat(uh2_r, ul2_r);
    v_res = round_sat(vh2_r, vl2_r);
    case (cmd2_r)
      CMD_ROT_X: begin
        ox_nxt = x2_r;
        oy_nxt = u_res;
        oz_nxt = v_res;
      end
      CMD_ROT_Y: begin
        ox_nxt = u_res;
        oy_nxt = y2_r;
        oz_nxt = v_res;
      end
      CMD_ROT_Z: begin
        ox_nxt = u_res;
        oy_nxt = v_res;
        oz_nxt = z2_r;
      end
      default: begin
        ox_nxt = x2_r;
        oy_nxt = y2_r;
        oz_nxt = z2_r;
      end
    endcase
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // select stage payload
  always_ff @(posedge clk) begin
    if (rdy0 && in_valid) begin
      cmd0_r <= cmd_in;
      x0_r   <= x_in;
      y0_r   <= y_in;
      z0_r   <= z_in;
      p0_r   <= p_nxt;
      q0_r   <= q_nxt;
      c0_r   <= c_nxt;
      sp0_r  <= sp_nxt;
      sn0_r  <= sn_nxt;
    end
  end

  // product stage payload: u = p*c + q*sn, v = q*c + p*sp
  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      cmd1_r <= cmd0_r;
      x1_r   <= x0_r;
      y1_r   <= y0_r;
      z1_r   <= z0_r;
      pch1_r <= PH_W'(p0_r) * PH_W'(ch);
      qnh1_r <= PH_W'(q0_r) * PH_W'(snh);
      qch1_r <= PH_W'(q0_r) * PH_W'(ch);
      psh1_r <= PH_W'(p0_r) * PH_W'(sph);
      pcl1_r <= PL_W'(p0_r) * PL_W'(cl);
      qnl1_r <= PL_W'(q0_r) * PL_W'(snl);
      qcl1_r <= PL_W'(q0_r) * PL_W'(cl);
      psl1_r <= PL_W'(p0_r) * PL_W'(spl);
    end
  end

  // partial sum stage payload, rounding half added on the low side
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      cmd2_r <= cmd1_r;
      x2_r   <= x1_r;
      y2_r   <= y1_r;
      z2_r   <= z1_r;
      uh2_r  <= HS_W'(pch1_r) + HS_W'(qnh1_r);
      vh2_r  <= HS_W'(qch1_r) + HS_W'(psh1_r);
      ul2_r  <= LS_W'(pcl1_r) + LS_W'(qnl1_r) + ROUND_HALF;
      vl2_r  <= LS_W'(qcl1_r) + LS_W'(psl1_r) + ROUND_HALF;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;

  a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> (c0_r <= TRIG_BOUND && c0_r >= -TRIG_BOUND &&
              sp0_r <= TRIG_BOUND && sp0_r >= -TRIG_BOUND))
    else $error("cosine or sine beyond unit magnitude");

  a_sine_pair: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |-> (sp0_r + sn0_r == '0))
    else $error("sine terms of the pair do not cancel");

endmodule
